/* hdl/urb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART ring buffer package
// Shared types, operation and status codes, and default sizes for the
// receive and transmit ring buffer block.
// ----------------------------------------------------------------------------
package urb_pkg;

    // Default ring capacities; each ring has one spare slot.
    localparam int URB_RX_CAPACITY = 15;
    localparam int URB_TX_CAPACITY = 15;

    // Depth of the request and result queues.
    localparam int URB_QUEUE_DEPTH = 2;

    // Operation codes.
    localparam logic [1:0] OP_HOST_READ  = 2'd0;
    localparam logic [1:0] OP_LINE_RX    = 2'd1;
    localparam logic [1:0] OP_HOST_WRITE = 2'd2;
    localparam logic [1:0] OP_TX_DONE    = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RX_EMPTY = 2'd1;
    localparam logic [1:0] ST_TX_FULL  = 2'd2;

    // Byte returned by a read of an empty receive ring.
    localparam logic [7:0] EMPTY_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic       line_send;
        logic [7:0] line_data;
        logic       overflow_flag;
        logic [3:0] rx_fill;
        logic [3:0] tx_fill;
    } out_item_t;

    // Decoded request handed from the front end to the ring engine.
    typedef struct packed {
        logic       rx_read;
        logic       rx_write;
        logic       tx_write;
        logic       tx_done;
        logic [7:0] data;
    } cmd_t;

endpackage
`default_nettype wire

/* hdl/urb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* hdl/urb_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out queue in flip-flops with push/full and pop/empty.
// ----------------------------------------------------------------------------
module urb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] dout,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

/* hdl/urb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ring buffer front end
// Accepts requests, decodes the operation code and queues the decoded
// request for the ring engine.
// ----------------------------------------------------------------------------
module urb_front import urb_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  wire logic     cmd_pop
);

    cmd_t cmd_in;
    logic cmd_empty;

    always_comb
    begin
        cmd_in      = '0;
        cmd_in.data = in_item.data_byte;
        case (in_item.op)
            OP_HOST_READ:  cmd_in.rx_read  = 1'b1;
            OP_LINE_RX:    cmd_in.rx_write = 1'b1;
            OP_HOST_WRITE: cmd_in.tx_write = 1'b1;
            default:       cmd_in.tx_done  = 1'b1;
        endcase
    end

    urb_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (URB_QUEUE_DEPTH)
    ) u_req_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (cmd),
        .empty (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;

endmodule
`default_nettype wire

/* hdl/urb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ring buffer engine
// Holds the receive and transmit ring state, carries out one decoded request
// per cycle while its result stage can take it, and forms its result when RAM data is ready.
// ----------------------------------------------------------------------------
module urb_back import urb_pkg::*; #(
    parameter int RX_CAPACITY = URB_RX_CAPACITY,
    parameter int TX_CAPACITY = URB_TX_CAPACITY
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    output logic      res_valid,
    output out_item_t res,
    input  wire logic res_ready
);

    localparam int RX_SLOTS = RX_CAPACITY + 1;
    localparam int TX_SLOTS = TX_CAPACITY + 1;
    localparam int RX_AW    = $clog2(RX_SLOTS);
    localparam int TX_AW    = $clog2(TX_SLOTS);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_CAPACITY);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_CAPACITY);

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_data;
        logic       rx_from_ram;
        logic       tx_from_ram;
        logic       line_send;
        logic [7:0] line_data;
        logic       overflow_flag;
        logic [3:0] rx_fill;
        logic [3:0] tx_fill;
    } stage_t;

    function automatic logic [RX_AW-1:0] rx_adv(input logic [RX_AW-1:0] p);
        return (p == RX_LAST) ? '0 : RX_AW'(p + 1'b1);
    endfunction

    function automatic logic [TX_AW-1:0] tx_adv(input logic [TX_AW-1:0] p);
        return (p == TX_LAST) ? '0 : TX_AW'(p + 1'b1);
    endfunction

    logic [RX_AW-1:0] rx_wr_pos_reg, rx_wr_pos_next;
    logic [RX_AW-1:0] rx_rd_pos_reg, rx_rd_pos_next;
    logic [RX_AW-1:0] rx_count_reg, rx_count_next;
    logic             rx_ovf_reg, rx_ovf_next;
    logic [TX_AW-1:0] tx_wr_pos_reg, tx_wr_pos_next;
    logic [TX_AW-1:0] tx_rd_pos_reg, tx_rd_pos_next;
    logic [TX_AW-1:0] tx_count_reg, tx_count_next;
    logic             tx_primed_reg, tx_primed_next;

    logic             s2_valid_reg;
    stage_t           s2_reg, s2_next;

    logic             fire, s2_ready;
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [TX_AW-1:0] tx_raddr;
    logic [TX_AW-1:0] tx_skip_pos;
    logic [TX_AW-1:0] tx_skip_count;
    logic [7:0]       rx_rdata, tx_rdata;

    assign s2_ready = !s2_valid_reg || res_ready;
    assign fire     = cmd_valid && s2_ready;
    assign cmd_pop  = fire;

    always_comb
    begin
        rx_wr_pos_next = rx_wr_pos_reg;
        rx_rd_pos_next = rx_rd_pos_reg;
        rx_count_next  = rx_count_reg;
        rx_ovf_next    = rx_ovf_reg;
        tx_wr_pos_next = tx_wr_pos_reg;
        tx_rd_pos_next = tx_rd_pos_reg;
        tx_count_next  = tx_count_reg;
        tx_primed_next = tx_primed_reg;
        rx_we          = 1'b0;
        rx_re          = 1'b0;
        tx_we          = 1'b0;
        tx_re          = 1'b0;
        s2_next        = '0;

        // A primed entry was already handed to the line when it was queued,
        // so transmit done drops it before taking the next byte.
        tx_skip_pos   = tx_primed_reg ? tx_adv(tx_rd_pos_reg) : tx_rd_pos_reg;
        tx_skip_count = tx_primed_reg ? TX_AW'(tx_count_reg - 1'b1) : tx_count_reg;
        tx_raddr      = tx_skip_pos;

        if (fire)
        begin
            if (cmd.rx_read)
            begin
                if (rx_count_reg == '0)
                begin
                    s2_next.status    = ST_RX_EMPTY;
                    s2_next.read_data = EMPTY_BYTE;
                end
                else
                begin
                    rx_re               = 1'b1;
                    s2_next.rx_from_ram = 1'b1;
                    rx_rd_pos_next      = rx_adv(rx_rd_pos_reg);
                    rx_count_next       = RX_AW'(rx_count_reg - 1'b1);
                end
            end
            else if (cmd.rx_write)
            begin
                // The byte lands even on overflow; the count saturates.
                rx_we          = 1'b1;
                rx_wr_pos_next = rx_adv(rx_wr_pos_reg);
                if (rx_count_reg == RX_LAST)
                begin
                    rx_ovf_next = 1'b1;
                end
                else
                begin
                    rx_count_next = RX_AW'(rx_count_reg + 1'b1);
                end
            end
            else if (cmd.tx_write)
            begin
                if (tx_count_reg == TX_LAST)
                begin
                    s2_next.status = ST_TX_FULL;
                end
                else
                begin
                    tx_we          = 1'b1;
                    tx_wr_pos_next = tx_adv(tx_wr_pos_reg);
                    tx_count_next  = TX_AW'(tx_count_reg + 1'b1);
                    if (tx_count_reg == '0)
                    begin
                        tx_primed_next    = 1'b1;
                        s2_next.line_send = 1'b1;
                        s2_next.line_data = cmd.data;
                    end
                end
            end
            else if (cmd.tx_done)
            begin
                if (tx_count_reg != '0)
                begin
                    tx_primed_next = 1'b0;
                    if (tx_skip_count != '0)
                    begin
                        tx_re               = 1'b1;
                        s2_next.tx_from_ram = 1'b1;
                        s2_next.line_send   = 1'b1;
                        tx_rd_pos_next      = tx_adv(tx_skip_pos);
                        tx_count_next       = TX_AW'(tx_skip_count - 1'b1);
                    end
                    else
                    begin
                        tx_rd_pos_next = tx_skip_pos;
                        tx_count_next  = tx_skip_count;
                    end
                end
            end
        end

        s2_next.overflow_flag = rx_ovf_next;
        s2_next.rx_fill       = 4'(rx_count_next);
        s2_next.tx_fill       = 4'(tx_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_pos_reg <= '0;
            rx_rd_pos_reg <= '0;
            rx_count_reg  <= '0;
            rx_ovf_reg    <= 1'b0;
            tx_wr_pos_reg <= '0;
            tx_rd_pos_reg <= '0;
            tx_count_reg  <= '0;
            tx_primed_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            rx_wr_pos_reg <= rx_wr_pos_next;
            rx_rd_pos_reg <= rx_rd_pos_next;
            rx_count_reg  <= rx_count_next;
            rx_ovf_reg    <= rx_ovf_next;
            tx_wr_pos_reg <= tx_wr_pos_next;
            tx_rd_pos_reg <= tx_rd_pos_next;
            tx_count_reg  <= tx_count_next;
            tx_primed_reg <= tx_primed_next;
            if (fire)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s2_reg <= s2_next;
        end
    end

    // Read data is only loaded on a firing request, so it holds while the
    // result stage waits.
    urb_ram #(
        .WIDTH (8),
        .DEPTH (RX_SLOTS),
        .AW    (RX_AW)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wr_pos_reg),
        .wdata (cmd.data),
        .re    (rx_re),
        .raddr (rx_rd_pos_reg),
        .rdata (rx_rdata)
    );

    urb_ram #(
        .WIDTH (8),
        .DEPTH (TX_SLOTS),
        .AW    (TX_AW)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wr_pos_reg),
        .wdata (cmd.data),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    assign res_valid         = s2_valid_reg;
    assign res.status        = s2_reg.status;
    assign res.read_data     = s2_reg.rx_from_ram ? rx_rdata : s2_reg.read_data;
    assign res.line_send     = s2_reg.line_send;
    assign res.line_data     = s2_reg.tx_from_ram ? tx_rdata : s2_reg.line_data;
    assign res.overflow_flag = s2_reg.overflow_flag;
    assign res.rx_fill       = s2_reg.rx_fill;
    assign res.tx_fill       = s2_reg.tx_fill;

endmodule
`default_nettype wire

/* hdl/uart_rx_tx_ring_buffers_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UART receive and transmit ring buffers
// Request channel: push an in_item while full is low. The op field selects
//   host read, line byte arrived, host write or transmit done.
// Result channel: while empty is low, out_item holds the oldest result; pop
//   takes it. Every request gives exactly one result, in request order.
// Path: a request passes the request queue, the ring engine's result
//   register and the result queue, each registered, before it shows on
//   out_item.
// Throughput: one request per cycle sustained while pop keeps up; the ring
//   engine takes one per cycle unless stalled, one read or write per RAM.
// When pop stays low, the result queue and the engine stage fill, then the
//   request queue fills and full rises; nothing is dropped.
// Reset clears both rings, their positions, counts, the overflow flag and
//   the primed mark; RAM contents are not cleared and are not needed.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_top import urb_pkg::*; #(
    parameter int RX_CAPACITY = URB_RX_CAPACITY,
    parameter int TX_CAPACITY = URB_TX_CAPACITY
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     out_item
);

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_pop;
    logic      res_valid;
    out_item_t res;
    logic      res_full;

    urb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    urb_back #(
        .RX_CAPACITY (RX_CAPACITY),
        .TX_CAPACITY (TX_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (!res_full)
    );

    urb_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (URB_QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_item),
        .empty (empty)
    );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ring buffer testbench
// Sends host reads, line arrivals, host writes and transmit-done events
// through the request queue, and keeps its own model of both rings. Each
// result that is popped is compared field by field with the oldest
// expected result. A short directed table covers empty reads, receive
// overflow, transmit refusal and the primed-entry skip. Random phases
// follow that fill and drain each ring, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import urb_pkg::*;

    localparam int RX_CAP       = URB_RX_CAPACITY;
    localparam int TX_CAP       = URB_TX_CAPACITY;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data_byte;
        int         reps;
        int         step;
        bit         checked;
        out_item_t  want;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;

    // Model of both rings.
    logic [7:0] rx_ring [RX_CAP + 1];
    logic [7:0] tx_ring [TX_CAP + 1];
    int         rx_wr, rx_rd, rx_cnt;
    int         tx_wr, tx_rd, tx_cnt;
    bit         rx_ovf, tx_primed;

    out_item_t  expected_results[$];
    stim_row_t  stim_rows[$];

    int  cycles;
    int  errors;
    int  requests_sent;
    int  results_checked;
    int  empty_reads;
    int  refused_writes;
    int  overflow_arrivals;
    int  line_sends;
    bit  send_quiet;

    uart_rx_tx_ring_buffers_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int next_slot(int pos, int cap);
        return (pos >= cap) ? 0 : pos + 1;
    endfunction

    function automatic out_item_t predict_ring_result(in_item_t req);
        out_item_t res;
        res = '0;
        case (req.op)
            OP_HOST_READ:
            begin
                if (rx_cnt == 0)
                begin
                    res.status    = ST_RX_EMPTY;
                    res.read_data = EMPTY_BYTE;
                end
                else
                begin
                    res.read_data = rx_ring[rx_rd];
                    rx_rd  = next_slot(rx_rd, RX_CAP);
                    rx_cnt = rx_cnt - 1;
                end
            end
            OP_LINE_RX:
            begin
                // On overflow the byte still lands and the write side moves on.
                rx_ring[rx_wr] = req.data_byte;
                rx_wr = next_slot(rx_wr, RX_CAP);
                if (rx_cnt >= RX_CAP)
                begin
                    rx_ovf = 1'b1;
                    overflow_arrivals++;
                end
                else
                    rx_cnt = rx_cnt + 1;
            end
            OP_HOST_WRITE:
            begin
                if (tx_cnt >= TX_CAP)
                    res.status = ST_TX_FULL;
                else
                begin
                    tx_ring[tx_wr] = req.data_byte;
                    tx_wr = next_slot(tx_wr, TX_CAP);
                    if (tx_cnt == 0)
                    begin
                        tx_primed     = 1'b1;
                        res.line_send = 1'b1;
                        res.line_data = req.data_byte;
                    end
                    tx_cnt = tx_cnt + 1;
                end
            end
            default:
            begin
                // The primed byte already went out when it was written.
                if (tx_cnt != 0 && tx_primed)
                begin
                    tx_primed = 1'b0;
                    tx_rd  = next_slot(tx_rd, TX_CAP);
                    tx_cnt = tx_cnt - 1;
                end
                if (tx_cnt != 0)
                begin
                    res.line_send = 1'b1;
                    res.line_data = tx_ring[tx_rd];
                    tx_rd  = next_slot(tx_rd, TX_CAP);
                    tx_cnt = tx_cnt - 1;
                end
            end
        endcase
        res.overflow_flag = rx_ovf;
        res.rx_fill       = 4'(rx_cnt);
        res.tx_fill       = 4'(tx_cnt);
        return res;
    endfunction

    function automatic string show(out_item_t v);
        return $sformatf("status=%0d read=%02h send=%0b line=%02h ovf=%0b rx=%0d tx=%0d",
                         v.status, v.read_data, v.line_send, v.line_data,
                         v.overflow_flag, v.rx_fill, v.tx_fill);
    endfunction

    function automatic void add_row(logic [1:0] op, logic [7:0] data_byte, int reps,
                                    int step, bit checked, out_item_t want);
        stim_row_t row;
        row.op        = op;
        row.data_byte = data_byte;
        row.reps      = reps;
        row.step      = step;
        row.checked   = checked;
        row.want      = want;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [1:0] pick_op(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            1:       return (r < 70) ? OP_LINE_RX : (r < 80) ? OP_HOST_READ :
                            (r < 90) ? OP_HOST_WRITE : OP_TX_DONE;
            2:       return (r < 70) ? OP_HOST_READ : (r < 85) ? OP_LINE_RX :
                            (r < 93) ? OP_HOST_WRITE : OP_TX_DONE;
            3:       return (r < 70) ? OP_HOST_WRITE : (r < 85) ? OP_TX_DONE :
                            (r < 93) ? OP_LINE_RX : OP_HOST_READ;
            4:       return (r < 60) ? OP_TX_DONE : (r < 80) ? OP_HOST_WRITE :
                            (r < 90) ? OP_LINE_RX : OP_HOST_READ;
            default: return 2'(r % 4);
        endcase
    endfunction

    // Waits a random gap, then holds the request until the block takes it.
    task automatic send_request(in_item_t req, bit checked, out_item_t want);
        int        gap;
        out_item_t predicted;
        gap = send_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= req;
        do
            @(posedge clk);
        while (full);
        predicted = predict_ring_result(req);
        if (predicted.status == ST_RX_EMPTY)
            empty_reads++;
        if (predicted.status == ST_TX_FULL)
            refused_writes++;
        if (predicted.line_send)
            line_sends++;
        expected_results.push_back(checked ? want : predicted);
        requests_sent++;
    endtask

    // Result side: random pop stalls, with stretches of back-to-back pops.
    initial
    begin
        int        stall;
        int        stretch_left;
        bit        recv_quiet;
        out_item_t want;
        stretch_left = 0;
        recv_quiet   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (stretch_left == 0)
            begin
                recv_quiet   = ($urandom_range(0, 2) == 0);
                stretch_left = $urandom_range(8, 40);
            end
            stretch_left--;
            stall = recv_quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with no request waiting: %s", $realtime,
                             show(out_item));
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (out_item.status !== want.status ||
                    out_item.read_data !== want.read_data ||
                    out_item.line_send !== want.line_send ||
                    out_item.line_data !== want.line_data ||
                    out_item.overflow_flag !== want.overflow_flag ||
                    out_item.rx_fill !== want.rx_fill ||
                    out_item.tx_fill !== want.tx_fill)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: result %0d mismatch\n  expected %s\n  actual   %s",
                                 $realtime, results_checked, show(want), show(out_item));
                end
            end
        end
    end

    initial
    begin
        in_item_t req;
        int       mode;
        int       phase_left;
        cycles            = 0;
        errors            = 0;
        requests_sent     = 0;
        results_checked   = 0;
        empty_reads       = 0;
        refused_writes    = 0;
        overflow_arrivals = 0;
        line_sends        = 0;
        send_quiet        = 1'b0;
        rx_wr = 0; rx_rd = 0; rx_cnt = 0; rx_ovf = 1'b0;
        tx_wr = 0; tx_rd = 0; tx_cnt = 0; tx_primed = 1'b0;
        rst_n   = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        in_item = '0;

        add_row(OP_HOST_READ, 8'h00, 1, 0, 1'b1,
                out_item_t'{ST_RX_EMPTY, EMPTY_BYTE, 1'b0, 8'h00, 1'b0, 4'd0, 4'd0});
        add_row(OP_TX_DONE, 8'h00, 1, 0, 1'b1,
                out_item_t'{ST_OK, 8'h00, 1'b0, 8'h00, 1'b0, 4'd0, 4'd0});
        add_row(OP_HOST_WRITE, 8'h00, 1, 0, 1'b1,
                out_item_t'{ST_OK, 8'h00, 1'b1, 8'h00, 1'b0, 4'd0, 4'd1});
        // Only the primed byte is queued, so it is skipped and nothing goes out.
        add_row(OP_TX_DONE, 8'hFF, 1, 0, 1'b1,
                out_item_t'{ST_OK, 8'h00, 1'b0, 8'h00, 1'b0, 4'd0, 4'd0});
        add_row(OP_LINE_RX, 8'h00, 1, 0, 1'b0, '0);
        add_row(OP_LINE_RX, 8'hFF, 1, 0, 1'b0, '0);
        add_row(OP_HOST_READ, 8'hFF, 2, 0, 1'b0, '0);
        add_row(OP_HOST_READ, 8'h00, 1, 0, 1'b0, '0);
        // Sixteen arrivals overflow the receive ring, two more lap the reader.
        add_row(OP_LINE_RX, 8'h10, 16, 1, 1'b0, '0);
        add_row(OP_LINE_RX, 8'h80, 2, 127, 1'b0, '0);
        add_row(OP_HOST_READ, 8'h00, 15, 0, 1'b0, '0);
        add_row(OP_HOST_READ, 8'h00, 1, 0, 1'b1,
                out_item_t'{ST_RX_EMPTY, EMPTY_BYTE, 1'b0, 8'h00, 1'b1, 4'd0, 4'd0});
        add_row(OP_HOST_WRITE, 8'hFF, 1, 0, 1'b0, '0);
        // Fill the transmit ring and have the last two writes refused.
        add_row(OP_HOST_WRITE, 8'h40, 16, 3, 1'b0, '0);
        add_row(OP_TX_DONE, 8'h00, 16, 0, 1'b0, '0);
        add_row(OP_HOST_WRITE, 8'hA5, 1, 0, 1'b0, '0);
        add_row(OP_HOST_WRITE, 8'h5A, 1, 0, 1'b0, '0);
        add_row(OP_TX_DONE, 8'h00, 3, 0, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
            for (int r = 0; r < stim_rows[i].reps; r++)
            begin
                req.op        = stim_rows[i].op;
                req.data_byte = stim_rows[i].data_byte + 8'(r * stim_rows[i].step);
                send_request(req, stim_rows[i].checked, stim_rows[i].want);
            end

        phase_left = 0;
        mode       = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(0, 4);
                phase_left = $urandom_range(10, 60);
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            req.op        = pick_op(mode);
            req.data_byte = 8'($urandom_range(0, 255));
            send_request(req, 1'b0, '0);
        end
        push <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests, %0d results checked, %0d errors",
                 requests_sent, results_checked, errors);
        $display("empty reads %0d, overflowing arrivals %0d, refused writes %0d, bytes sent %0d",
                 empty_reads, overflow_arrivals, refused_writes, line_sends);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
